>>> src/point_in_triangle_test_top_defines.svh
// assertion macros for the point-in-triangle test block
// used by point_in_triangle_test_top; expects clk_i and rst_ni in scope
`ifndef POINT_IN_TRIANGLE_TEST_TOP_DEFINES_SVH
`define POINT_IN_TRIANGLE_TEST_TOP_DEFINES_SVH

// checked on every clock edge outside of reset
`define PIT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define PIT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> src/pit_pkg.sv
// shared types and constants of the point-in-triangle test block
// no dependencies; imported by pit_datapath and point_in_triangle_test_top
package pit_pkg;

  localparam int CoordBits   = 16;
  localparam int DiffBits    = CoordBits + 1;
  localparam int ProdBits    = 2 * DiffBits;
  localparam int CrossBits   = ProdBits + 1;
  localparam int SumBits     = CrossBits + 1;
  localparam int InTdataBits = ((2 * CoordBits + 7) / 8) * 8;
  localparam int OutTdataBits = 8;
  localparam int CfgIndexBits = 3;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef enum logic [CfgIndexBits-1:0] {
    REG_A_X = 3'd0,
    REG_A_Y = 3'd1,
    REG_B_X = 3'd2,
    REG_B_Y = 3'd3,
    REG_C_X = 3'd4,
    REG_C_Y = 3'd5
  } reg_index_e;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t cx;
    coord_t cy;
  } vertex_set_t;

  typedef struct packed {
    logic advance;
    logic valid;
  } pit_ctrl_t;

  typedef struct packed {
    logic degenerate;
    logic inside_res;
  } pit_result_t;

endpackage

>>> src/pit_datapath.sv
// three-stage arithmetic pipeline: differences, products, cross products
// depends on pit_pkg; the result is decoded from the last stage
module pit_datapath import pit_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pit_ctrl_t   ctrl_i,
  input  vertex_set_t vert_i,
  input  coord_t      point_x_i,
  input  coord_t      point_y_i,
  output logic        valid_o,
  output pit_result_t result_o
);

  // stage 1: edge vectors and point offset
  logic signed [DiffBits-1:0] e0x_q, e0y_q, e1x_q, e1y_q, wx_q, wy_q;
  logic signed [DiffBits-1:0] e0x_d, e0y_d, e1x_d, e1y_d, wx_d, wy_d;
  // stage 2: the six products
  logic signed [ProdBits-1:0] k0_q, k1_q, s0_q, s1_q, t0_q, t1_q;
  logic signed [ProdBits-1:0] k0_d, k1_d, s0_d, s1_d, t0_d, t1_d;
  // stage 3: cross products
  logic signed [CrossBits-1:0] k_q, s_q, t_q, k_d, s_d, t_d;
  logic signed [SumBits-1:0]   st_sum, k_ext;
  logic v1_q, v2_q, v3_q;

  function automatic logic signed [DiffBits-1:0] sub_coord(coord_t a, coord_t b);
    return {a[CoordBits-1], a} - {b[CoordBits-1], b};
  endfunction

  function automatic logic signed [CrossBits-1:0] sub_prod(
    logic signed [ProdBits-1:0] a, logic signed [ProdBits-1:0] b);
    return {a[ProdBits-1], a} - {b[ProdBits-1], b};
  endfunction

  always_comb begin
    e0x_d = sub_coord(vert_i.cx, vert_i.ax);
    e0y_d = sub_coord(vert_i.cy, vert_i.ay);
    e1x_d = sub_coord(vert_i.bx, vert_i.ax);
    e1y_d = sub_coord(vert_i.by, vert_i.ay);
    wx_d  = sub_coord(point_x_i, vert_i.ax);
    wy_d  = sub_coord(point_y_i, vert_i.ay);
  end

  always_comb begin
    k0_d = ProdBits'(e0x_q * e1y_q);
    k1_d = ProdBits'(e0y_q * e1x_q);
    s0_d = ProdBits'(wx_q * e1y_q);
    s1_d = ProdBits'(wy_q * e1x_q);
    t0_d = ProdBits'(e0x_q * wy_q);
    t1_d = ProdBits'(e0y_q * wx_q);
  end

  always_comb begin
    k_d = sub_prod(k0_q, k1_q);
    s_d = sub_prod(s0_q, s1_q);
    t_d = sub_prod(t0_q, t1_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (ctrl_i.advance) begin
      v1_q <= ctrl_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      e0x_q <= e0x_d;
      e0y_q <= e0y_d;
      e1x_q <= e1x_d;
      e1y_q <= e1y_d;
      wx_q  <= wx_d;
      wy_q  <= wy_d;
      k0_q  <= k0_d;
      k1_q  <= k1_d;
      s0_q  <= s0_d;
      s1_q  <= s1_d;
      t0_q  <= t0_d;
      t1_q  <= t1_d;
      k_q   <= k_d;
      s_q   <= s_d;
      t_q   <= t_d;
    end
  end

  // sign tests and the u + v < 1 compare, reversed for clockwise winding
  always_comb begin
    st_sum = {s_q[CrossBits-1], s_q} + {t_q[CrossBits-1], t_q};
    k_ext  = {k_q[CrossBits-1], k_q};
    result_o.degenerate = (k_q == '0);
    if (k_q == '0) begin
      result_o.inside_res = 1'b0;
    end else if (!k_q[CrossBits-1]) begin
      result_o.inside_res = !s_q[CrossBits-1] && !t_q[CrossBits-1] && (st_sum < k_ext);
    end else begin
      result_o.inside_res = (s_q <= 0) && (t_q <= 0) && (st_sum > k_ext);
    end
  end

  assign valid_o = v3_q;

endmodule

>>> src/point_in_triangle_test_top.sv
// top level of the point-in-triangle test: vertex registers, stream ports, output register
// depends on pit_pkg, pit_datapath and point_in_triangle_test_top_defines.svh
//
// Usage:
//   The triangle A, B, C sits in six signed Q12.4 registers written over the cfg
//   channel (index 0..5 = a_x, a_y, b_x, b_y, c_x, c_y; other indexes are dropped).
//   cfg_ready_o is always high. Write the vertices only while no query is in flight.
//   Each transaction on the s_axis side carries one query point; the m_axis side
//   returns one transaction per query with inside_res and degenerate.
//   Pipeline: four register stages (differences, six 17x17 products, cross
//   products, output register). Throughput: one query per cycle while the
//   receiver does not stall, set by the fully pipelined multiplier stage.
//   Reset clears the vertex registers to zero and empties the pipeline; with all
//   vertices at zero every query reports degenerate.
//   When the receiver stalls, the whole pipeline holds and s_axis_tready drops in
//   the same cycle; nothing is dropped or repeated.
`include "point_in_triangle_test_top_defines.svh"

module point_in_triangle_test_top import pit_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // fields from bit 0: point_x, point_y
  input  logic [InTdataBits-1:0]  s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // fields from bit 0: inside_res, degenerate, zero padding
  output logic [OutTdataBits-1:0] m_axis_tdata,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIndexBits-1:0] cfg_index_i,
  input  logic [CoordBits-1:0]    cfg_data_i
);

  vertex_set_t vert_q;
  pit_ctrl_t   ctrl;
  pit_result_t dp_result, result_q;
  logic        dp_valid, out_valid_q, advance;
  coord_t      point_x, point_y;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vert_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (reg_index_e'(cfg_index_i))
        REG_A_X: vert_q.ax <= cfg_data_i;
        REG_A_Y: vert_q.ay <= cfg_data_i;
        REG_B_X: vert_q.bx <= cfg_data_i;
        REG_B_Y: vert_q.by <= cfg_data_i;
        REG_C_X: vert_q.cx <= cfg_data_i;
        REG_C_Y: vert_q.cy <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // the pipeline moves as a whole whenever the output slot is free or draining
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = advance;
  assign ctrl.advance  = advance;
  assign ctrl.valid    = s_axis_tvalid;

  assign point_x = s_axis_tdata[CoordBits-1:0];
  assign point_y = s_axis_tdata[2*CoordBits-1:CoordBits];

  pit_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .vert_i    (vert_q),
    .point_x_i (point_x),
    .point_y_i (point_y),
    .valid_o   (dp_valid),
    .result_o  (dp_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= dp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= dp_result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutTdataBits-2)'(0), result_q.degenerate, result_q.inside_res};

  `PIT_ASSERT(a_degen_never_inside, m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]), "degenerate result reported inside")
  `PIT_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output slot")
  `PIT_ASSERT(a_out_from_pipe, $rose(m_axis_tvalid) |-> $past(dp_valid), "result appeared without a pipeline transaction")
  `PIT_ASSERT(a_zero_triangle_degen, (m_axis_tvalid && vert_q == '0) |-> m_axis_tdata[1], "zero triangle not flagged degenerate")
  `PIT_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !m_axis_tvalid, "output valid during reset")

endmodule
